>>> hw/rtl/prc_pkg.sv
// Shared constants, types and sine table builder for the point rotation block.
package prc_pkg;

   localparam int TRIG_FRAC_BITS_DEF = 16;
   localparam int TRIG_FRAC_MAX      = 24;

   localparam int COORD_W = 32;
   localparam int ANGLE_W = 16;
   localparam int DIFF_W  = COORD_W + 1;

   localparam int FULL_TURN    = 360;
   localparam int QUARTER_TURN = 90;
   localparam int HALF_QUARTER = QUARTER_TURN / 2;

   localparam int BIASED_W    = ANGLE_W + 1;
   localparam int ANGLE_BIAS  = 92 * FULL_TURN;
   localparam int ANGLE_RECIP = 46604;
   localparam int RECIP_SHIFT = 24;
   localparam int TURNS_W     = 8;
   localparam int ANGLE_MOD_W = 9;
   localparam int REM_W       = 7;

   localparam int SINCOS_LATENCY = 4;
   localparam int CENTER_DELAY   = SINCOS_LATENCY + 2;
   localparam int PIPE_DEPTH     = SINCOS_LATENCY + 3;

   localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

   localparam logic [63:0] DEG_Q31 = 64'd37480660;
   localparam logic [63:0] ONE_Q31 = 64'd2147483648;

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } quadrant_type;

   typedef logic [TRIG_FRAC_MAX:0] trig_entry_type;
   typedef trig_entry_type trig_table_type [0:QUARTER_TURN];

   function automatic logic [63:0] sin_q31(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      longint      acc;
      x2  = (x * x) >> 31;
      t   = x;
      acc = longint'(t);
      t   = ((t * x2) >> 31) / 64'd6;
      acc = acc - longint'(t);
      t   = ((t * x2) >> 31) / 64'd20;
      acc = acc + longint'(t);
      t   = ((t * x2) >> 31) / 64'd42;
      acc = acc - longint'(t);
      t   = ((t * x2) >> 31) / 64'd72;
      acc = acc + longint'(t);
      t   = ((t * x2) >> 31) / 64'd110;
      acc = acc - longint'(t);
      t   = ((t * x2) >> 31) / 64'd156;
      acc = acc + longint'(t);
      if (acc < 0) begin
         acc = 0;
      end
      return 64'(acc);
   endfunction

   function automatic logic [63:0] cos_q31(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      longint      acc;
      x2  = (x * x) >> 31;
      t   = ONE_Q31;
      acc = longint'(t);
      t   = ((t * x2) >> 31) / 64'd2;
      acc = acc - longint'(t);
      t   = ((t * x2) >> 31) / 64'd12;
      acc = acc + longint'(t);
      t   = ((t * x2) >> 31) / 64'd30;
      acc = acc - longint'(t);
      t   = ((t * x2) >> 31) / 64'd56;
      acc = acc + longint'(t);
      t   = ((t * x2) >> 31) / 64'd90;
      acc = acc - longint'(t);
      t   = ((t * x2) >> 31) / 64'd132;
      acc = acc + longint'(t);
      if (acc < 0) begin
         acc = 0;
      end
      return 64'(acc);
   endfunction

   function automatic trig_entry_type trig_entry(input int unsigned d, input int frac);
      logic [63:0] v;
      if (d <= HALF_QUARTER) begin
         v = sin_q31(64'(d) * DEG_Q31);
      end else begin
         v = cos_q31(64'(QUARTER_TURN - d) * DEG_Q31);
      end
      v = (v + (64'd1 << (30 - frac))) >> (31 - frac);
      return v[TRIG_FRAC_MAX:0];
   endfunction

   function automatic trig_table_type build_table(input int frac);
      trig_table_type tbl;
      for (int d = 0; d <= QUARTER_TURN; d++) begin
         tbl[d] = trig_entry(d, frac);
      end
      return tbl;
   endfunction

endpackage

>>> hw/rtl/point_rotation_about_center_top.sv
// Top level: pipelined rotation of a Q24.8 point about a center by whole degrees.
//
//   port group  direction  beat marked by     content
//   req_        in         start & !busy      point, center, angle in degrees
//   rsp_        out        rsp_valid          rotated point, clipped flag
//
// One beat enters per cycle while busy is low, without waiting for earlier results.
// The depth is set by the angle reduction and table lookup (four stages)
// followed by the products, the rounding sum and the center add with saturation.
// Reset clears the valid pipeline and holds busy high until the cycle after it.
// The receiver cannot stall, so the pipeline always advances.
module point_rotation_about_center_top #(
   parameter int TRIG_FRAC_BITS = prc_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [prc_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [prc_pkg::COORD_W-1:0]    req_point_y,
   input  logic signed [prc_pkg::COORD_W-1:0]    req_center_x,
   input  logic signed [prc_pkg::COORD_W-1:0]    req_center_y,
   input  logic signed [prc_pkg::ANGLE_W-1:0]    req_angle_deg,
   output logic                                  rsp_valid,
   output logic signed [prc_pkg::COORD_W-1:0]    rsp_rotated_x,
   output logic signed [prc_pkg::COORD_W-1:0]    rsp_rotated_y,
   output logic                                  rsp_clipped
);

   localparam int TW   = TRIG_FRAC_BITS + 2;
   localparam int PW   = prc_pkg::DIFF_W + TW;
   localparam int SW   = PW + 1;
   localparam int RW   = SW - TRIG_FRAC_BITS;
   localparam int TOTW = RW + 1;
   localparam int CW   = prc_pkg::COORD_W;

   localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (TRIG_FRAC_BITS - 1);

   logic                         busy_ff;
   logic [prc_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic                         accept;

   logic signed [prc_pkg::DIFF_W-1:0] dx_ff [prc_pkg::SINCOS_LATENCY];
   logic signed [prc_pkg::DIFF_W-1:0] dy_ff [prc_pkg::SINCOS_LATENCY];
   logic signed [CW-1:0]              cx_ff [prc_pkg::CENTER_DELAY];
   logic signed [CW-1:0]              cy_ff [prc_pkg::CENTER_DELAY];

   logic signed [TW-1:0] sin_val;
   logic signed [TW-1:0] cos_val;

   logic signed [PW-1:0] prod_xc_ff;
   logic signed [PW-1:0] prod_ys_ff;
   logic signed [PW-1:0] prod_xs_ff;
   logic signed [PW-1:0] prod_yc_ff;

   logic signed [SW-1:0] sum_x;
   logic signed [SW-1:0] sum_y;
   logic signed [RW-1:0] rnd_x_ff;
   logic signed [RW-1:0] rnd_y_ff;

   logic signed [TOTW-1:0] tot_x;
   logic signed [TOTW-1:0] tot_y;
   logic                   ovf_x;
   logic                   ovf_y;
   logic signed [CW-1:0]   sat_x;
   logic signed [CW-1:0]   sat_y;
   logic signed [CW-1:0]   rsp_rotated_x_ff;
   logic signed [CW-1:0]   rsp_rotated_y_ff;
   logic                   rsp_clipped_ff;

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   prc_sincos #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_sincos (
      .clock     (clock),
      .angle_deg (req_angle_deg),
      .sin_val   (sin_val),
      .cos_val   (cos_val)
   );

   always_comb begin
      sum_x = {prod_xc_ff[PW-1], prod_xc_ff} - {prod_ys_ff[PW-1], prod_ys_ff} + ROUND_HALF;
      sum_y = {prod_xs_ff[PW-1], prod_xs_ff} + {prod_yc_ff[PW-1], prod_yc_ff} + ROUND_HALF;
   end

   always_comb begin
      tot_x = {rnd_x_ff[RW-1], rnd_x_ff}
            + TOTW'(cx_ff[prc_pkg::CENTER_DELAY-1]);
      tot_y = {rnd_y_ff[RW-1], rnd_y_ff}
            + TOTW'(cy_ff[prc_pkg::CENTER_DELAY-1]);
      ovf_x = tot_x[TOTW-1:CW-1] != {(TOTW-CW+1){tot_x[CW-1]}};
      ovf_y = tot_y[TOTW-1:CW-1] != {(TOTW-CW+1){tot_y[CW-1]}};
      if (ovf_x) begin
         sat_x = tot_x[TOTW-1] ? prc_pkg::COORD_MIN : prc_pkg::COORD_MAX;
      end else begin
         sat_x = tot_x[CW-1:0];
      end
      if (ovf_y) begin
         sat_y = tot_y[TOTW-1] ? prc_pkg::COORD_MIN : prc_pkg::COORD_MAX;
      end else begin
         sat_y = tot_y[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= {valid_ff[prc_pkg::PIPE_DEPTH-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      dx_ff[0] <= {req_point_x[CW-1], req_point_x} - {req_center_x[CW-1], req_center_x};
      dy_ff[0] <= {req_point_y[CW-1], req_point_y} - {req_center_y[CW-1], req_center_y};
      for (int i = 1; i < prc_pkg::SINCOS_LATENCY; i++) begin
         dx_ff[i] <= dx_ff[i-1];
         dy_ff[i] <= dy_ff[i-1];
      end
      cx_ff[0] <= req_center_x;
      cy_ff[0] <= req_center_y;
      for (int i = 1; i < prc_pkg::CENTER_DELAY; i++) begin
         cx_ff[i] <= cx_ff[i-1];
         cy_ff[i] <= cy_ff[i-1];
      end
      prod_xc_ff       <= PW'(dx_ff[prc_pkg::SINCOS_LATENCY-1]) * PW'(cos_val);
      prod_ys_ff       <= PW'(dy_ff[prc_pkg::SINCOS_LATENCY-1]) * PW'(sin_val);
      prod_xs_ff       <= PW'(dx_ff[prc_pkg::SINCOS_LATENCY-1]) * PW'(sin_val);
      prod_yc_ff       <= PW'(dy_ff[prc_pkg::SINCOS_LATENCY-1]) * PW'(cos_val);
      rnd_x_ff         <= sum_x[SW-1:TRIG_FRAC_BITS];
      rnd_y_ff         <= sum_y[SW-1:TRIG_FRAC_BITS];
      rsp_rotated_x_ff <= sat_x;
      rsp_rotated_y_ff <= sat_y;
      rsp_clipped_ff   <= ovf_x | ovf_y;
   end

   assign rsp_valid     = valid_ff[prc_pkg::PIPE_DEPTH-1];
   assign rsp_rotated_x = rsp_rotated_x_ff;
   assign rsp_rotated_y = rsp_rotated_y_ff;
   assign rsp_clipped   = rsp_clipped_ff;

endmodule

>>> hw/rtl/prc_sincos.sv
// Angle reduction and quadrant table lookup pipeline giving sine and cosine.
module prc_sincos #(
   parameter int TRIG_FRAC_BITS = prc_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic signed [prc_pkg::ANGLE_W-1:0]     angle_deg,
   output logic signed [TRIG_FRAC_BITS+1:0]       sin_val,
   output logic signed [TRIG_FRAC_BITS+1:0]       cos_val
);

   localparam int TW    = TRIG_FRAC_BITS + 2;
   localparam int PRODW = 2 * prc_pkg::BIASED_W - 1;

   localparam prc_pkg::trig_table_type TRIG_TABLE = prc_pkg::build_table(TRIG_FRAC_BITS);

   logic [prc_pkg::BIASED_W-1:0]    biased_in;
   logic [prc_pkg::BIASED_W-1:0]    biased_a_ff;
   logic [prc_pkg::BIASED_W-1:0]    biased_b_ff;
   logic [PRODW-1:0]                recip_prod;
   logic [prc_pkg::TURNS_W-1:0]     turns_b_ff;
   logic [prc_pkg::BIASED_W-1:0]    rem_full;
   logic [prc_pkg::ANGLE_MOD_W-1:0] angle_mod;
   logic [prc_pkg::ANGLE_MOD_W-1:0] rem_wide;
   prc_pkg::quadrant_type           quad_in;
   prc_pkg::quadrant_type           quad_ff;
   logic [prc_pkg::REM_W-1:0]       rem_ff;
   prc_pkg::trig_entry_type         entry_lo;
   prc_pkg::trig_entry_type         entry_hi;
   logic signed [TW-1:0]            val_lo;
   logic signed [TW-1:0]            val_hi;
   logic signed [TW-1:0]            sin_in;
   logic signed [TW-1:0]            cos_in;
   logic signed [TW-1:0]            sin_ff;
   logic signed [TW-1:0]            cos_ff;

   assign biased_in = {angle_deg[prc_pkg::ANGLE_W-1], angle_deg}
                    + prc_pkg::BIASED_W'(prc_pkg::ANGLE_BIAS);

   assign recip_prod = PRODW'(biased_a_ff) * PRODW'(prc_pkg::ANGLE_RECIP);

   assign rem_full  = biased_b_ff
                    - prc_pkg::BIASED_W'(turns_b_ff) * prc_pkg::BIASED_W'(prc_pkg::FULL_TURN);
   assign angle_mod = rem_full[prc_pkg::ANGLE_MOD_W-1:0];

   always_comb begin
      if (angle_mod >= prc_pkg::ANGLE_MOD_W'(3 * prc_pkg::QUARTER_TURN)) begin
         quad_in  = prc_pkg::QUAD_3;
         rem_wide = angle_mod - prc_pkg::ANGLE_MOD_W'(3 * prc_pkg::QUARTER_TURN);
      end else if (angle_mod >= prc_pkg::ANGLE_MOD_W'(2 * prc_pkg::QUARTER_TURN)) begin
         quad_in  = prc_pkg::QUAD_2;
         rem_wide = angle_mod - prc_pkg::ANGLE_MOD_W'(2 * prc_pkg::QUARTER_TURN);
      end else if (angle_mod >= prc_pkg::ANGLE_MOD_W'(prc_pkg::QUARTER_TURN)) begin
         quad_in  = prc_pkg::QUAD_1;
         rem_wide = angle_mod - prc_pkg::ANGLE_MOD_W'(prc_pkg::QUARTER_TURN);
      end else begin
         quad_in  = prc_pkg::QUAD_0;
         rem_wide = angle_mod;
      end
   end

   always_comb begin
      entry_lo = TRIG_TABLE[rem_ff];
      entry_hi = TRIG_TABLE[prc_pkg::REM_W'(prc_pkg::QUARTER_TURN) - rem_ff];
      val_lo   = {1'b0, entry_lo[TRIG_FRAC_BITS:0]};
      val_hi   = {1'b0, entry_hi[TRIG_FRAC_BITS:0]};
      case (quad_ff)
         prc_pkg::QUAD_0: begin
            sin_in = val_lo;
            cos_in = val_hi;
         end
         prc_pkg::QUAD_1: begin
            sin_in = val_hi;
            cos_in = -val_lo;
         end
         prc_pkg::QUAD_2: begin
            sin_in = -val_lo;
            cos_in = -val_hi;
         end
         prc_pkg::QUAD_3: begin
            sin_in = -val_hi;
            cos_in = val_lo;
         end
         default: begin
            sin_in = val_lo;
            cos_in = val_hi;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      biased_a_ff <= biased_in;
      biased_b_ff <= biased_a_ff;
      turns_b_ff  <= recip_prod[prc_pkg::RECIP_SHIFT +: prc_pkg::TURNS_W];
      quad_ff     <= quad_in;
      rem_ff      <= rem_wide[prc_pkg::REM_W-1:0];
      sin_ff      <= sin_in;
      cos_ff      <= cos_in;
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

>>> tb/sv/point_rotation_about_center_top_tb.sv
// Self-checking testbench for the point rotation block: directed table, then random beats.
module point_rotation_about_center_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import prc_pkg::*;

   localparam int     CLK_PERIOD   = 8;
   localparam int     RESET_CYCLES = 12;
   localparam int     RANDOM_BEATS = 1900;
   localparam int     TRIG_FRAC    = TRIG_FRAC_BITS_DEF;
   localparam longint COORD_HI     = 64'sd2147483647;
   localparam longint COORD_LO     = -64'sd2147483648;
   localparam longint ROUND_HALF   = longint'(1) << (TRIG_FRAC - 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [ANGLE_W-1:0] angle_deg;
   } rot_beat_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] rotated_x;
      logic signed [COORD_W-1:0] rotated_y;
      logic                      clipped;
   } rot_result_type;

   typedef struct {
      rot_beat_type   beat;
      bit             typed;
      rot_result_type want;
   } rot_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [COORD_W-1:0] req_point_x;
   logic signed [COORD_W-1:0] req_point_y;
   logic signed [COORD_W-1:0] req_center_x;
   logic signed [COORD_W-1:0] req_center_y;
   logic signed [ANGLE_W-1:0] req_angle_deg;
   logic                      rsp_valid;
   logic signed [COORD_W-1:0] rsp_rotated_x;
   logic signed [COORD_W-1:0] rsp_rotated_y;
   logic                      rsp_clipped;

   longint         sine_quadrant [0:QUARTER_TURN];
   rot_result_type expected_rotations [$];
   rot_row_type    directed_rows [$];
   int             mismatch_count = 0;
   int             beats_sent     = 0;
   int             results_seen   = 0;
   int             clipped_seen   = 0;

   point_rotation_about_center_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_angle_deg (req_angle_deg),
      .rsp_valid     (rsp_valid),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .rsp_clipped   (rsp_clipped)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [63:0] taylor_q31(input logic [63:0] x, input bit want_cos);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] step;
      longint      acc;
      x2   = (x * x) >> 31;
      term = want_cos ? ONE_Q31 : x;
      acc  = longint'(term);
      for (int k = 1; k <= 6; k++) begin
         step = want_cos ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
         term = ((term * x2) >> 31) / step;
         acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      return (acc < 0) ? 64'd0 : 64'(acc);
   endfunction

   function automatic logic [COORD_W-1:0] saturate(input longint v, inout logic clip);
      if (v > COORD_HI) begin
         clip = 1'b1;
         return COORD_MAX;
      end else if (v < COORD_LO) begin
         clip = 1'b1;
         return COORD_MIN;
      end
      return COORD_W'(v);
   endfunction

   function automatic rot_result_type rotate_about_center(input rot_beat_type b);
      longint         ang;
      longint         turn;
      longint         s;
      longint         c;
      longint         dx;
      longint         dy;
      int             rem;
      logic           clip;
      quadrant_type   quad;
      rot_result_type res;
      ang  = longint'(b.angle_deg);
      turn = ((ang % FULL_TURN) + FULL_TURN) % FULL_TURN;
      quad = quadrant_type'(turn / QUARTER_TURN);
      rem  = int'(turn % QUARTER_TURN);
      case (quad)
         QUAD_0: begin
            s = sine_quadrant[rem];
            c = sine_quadrant[QUARTER_TURN - rem];
         end
         QUAD_1: begin
            s = sine_quadrant[QUARTER_TURN - rem];
            c = -sine_quadrant[rem];
         end
         QUAD_2: begin
            s = -sine_quadrant[rem];
            c = -sine_quadrant[QUARTER_TURN - rem];
         end
         default: begin
            s = -sine_quadrant[QUARTER_TURN - rem];
            c = sine_quadrant[rem];
         end
      endcase
      dx   = longint'(b.point_x) - longint'(b.center_x);
      dy   = longint'(b.point_y) - longint'(b.center_y);
      clip = 1'b0;
      res.rotated_x = saturate(((dx * c - dy * s + ROUND_HALF) >>> TRIG_FRAC)
                               + longint'(b.center_x), clip);
      res.rotated_y = saturate(((dx * s + dy * c + ROUND_HALF) >>> TRIG_FRAC)
                               + longint'(b.center_y), clip);
      res.clipped   = clip;
      return res;
   endfunction

   function automatic logic [COORD_W-1:0] pick_boundary_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return COORD_MAX - $urandom_range(0, 1 << 16);
         3: return COORD_MIN + $urandom_range(0, 1 << 16);
         4: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic rot_beat_type random_beat();
      rot_beat_type b;
      int unsigned  pick;
      pick        = $urandom_range(0, 99);
      b.angle_deg = ANGLE_W'($urandom);
      if (pick < 60) begin
         b.center_x = $urandom_range(0, 1 << 21) - (1 << 20);
         b.center_y = $urandom_range(0, 1 << 21) - (1 << 20);
         b.point_x  = b.center_x + ($urandom_range(0, 1 << 17) - (1 << 16));
         b.point_y  = b.center_y + ($urandom_range(0, 1 << 17) - (1 << 16));
         if (pick < 20) begin
            b.angle_deg = ANGLE_W'($urandom_range(0, 4 * FULL_TURN) - 2 * FULL_TURN);
         end else if (pick < 35) begin
            b.angle_deg = ANGLE_W'(QUARTER_TURN * ($urandom_range(0, 40) - 20)
                                   + $urandom_range(0, 2) - 1);
         end else if (pick < 45) begin
            b.angle_deg = ANGLE_W'((QUARTER_TURN / 3) * ($urandom_range(0, 48) - 24));
         end
      end else if (pick < 80) begin
         b.point_x  = $urandom;
         b.point_y  = $urandom;
         b.center_x = $urandom;
         b.center_y = $urandom;
      end else begin
         b.point_x  = pick_boundary_coord();
         b.point_y  = pick_boundary_coord();
         b.center_x = pick_boundary_coord();
         b.center_y = pick_boundary_coord();
      end
      return b;
   endfunction

   task automatic add_row(input int px, input int py, input int cx, input int cy,
                          input int ang, input bit typed,
                          input int rx, input int ry, input bit clip);
      rot_row_type r;
      r.beat  = '{point_x: px, point_y: py, center_x: cx, center_y: cy,
                  angle_deg: ANGLE_W'(ang)};
      r.typed = typed;
      r.want  = '{rotated_x: rx, rotated_y: ry, clipped: clip};
      directed_rows.push_back(r);
   endtask

   task automatic send_beat(input rot_beat_type b, input rot_result_type want);
      req_point_x   <= b.point_x;
      req_point_y   <= b.point_y;
      req_center_x  <= b.center_x;
      req_center_y  <= b.center_y;
      req_angle_deg <= b.angle_deg;
      start         <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected_rotations.push_back(want);
      beats_sent++;
   endtask

   task automatic maybe_idle(input bit quiet);
      if (!quiet && $urandom_range(0, 99) < 15) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained(input int limit);
      start <= 1'b0;
      for (int n = 0; n < limit && expected_rotations.size() != 0; n++) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d",
                  $time, what, $signed(want), $signed(got));
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rot_result_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (rsp_valid !== 1'b1) begin
            $display("%0t ns: rsp_valid unknown, expected 0 or 1, got %b", $time, rsp_valid);
            mismatch_count++;
         end else if (expected_rotations.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got x=%0d y=%0d clipped=%b",
                     $time, rsp_rotated_x, rsp_rotated_y, rsp_clipped);
            mismatch_count++;
         end else begin
            want = expected_rotations.pop_front();
            check_field("rotated_x", want.rotated_x, rsp_rotated_x);
            check_field("rotated_y", want.rotated_y, rsp_rotated_y);
            check_field("clipped", COORD_W'(want.clipped), COORD_W'(rsp_clipped));
            results_seen++;
            if (rsp_clipped === 1'b1) begin
               clipped_seen++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [63:0]  raw;
      rot_beat_type beat;
      for (int d = 0; d <= QUARTER_TURN; d++) begin
         if (d <= HALF_QUARTER) begin
            raw = taylor_q31(64'(d) * DEG_Q31, 1'b0);
         end else begin
            raw = taylor_q31(64'(QUARTER_TURN - d) * DEG_Q31, 1'b1);
         end
         sine_quadrant[d] = longint'((raw + (64'd1 << (30 - TRIG_FRAC))) >> (31 - TRIG_FRAC));
      end

      reset         <= 1'b1;
      start         <= 1'b0;
      req_point_x   <= '0;
      req_point_y   <= '0;
      req_center_x  <= '0;
      req_center_y  <= '0;
      req_angle_deg <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      add_row(0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row('h100, 'h200, 0, 0, 0, 1, 'h100, 'h200, 0);
      add_row('h100, 0, 0, 0, 90, 1, 0, 'h100, 0);
      add_row('h100, 'h200, 0, 0, 180, 1, -'h100, -'h200, 0);
      add_row('h100, 0, 0, 0, 270, 1, 0, -'h100, 0);
      add_row('h100, 0, 0, 0, -90, 1, 0, -'h100, 0);
      add_row('h300, -'h500, 'h100, 'h100, 360, 1, 'h300, -'h500, 0);
      add_row('h500, 'h200, 'h100, 'h100, 90, 1, 0, 'h500, 0);
      add_row(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, 1, COORD_MAX, COORD_MIN, 0);
      add_row(COORD_MIN, 0, 0, 0, 180, 1, COORD_MAX, 0, 1);
      add_row(0, COORD_MIN, 0, 0, 180, 1, 0, COORD_MAX, 1);
      add_row(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 180, 1, COORD_MIN, COORD_MIN, 1);
      add_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 180, 1, COORD_MAX, COORD_MAX, 1);
      add_row(1, 0, 0, 0, 30, 0, 0, 0, 0);
      add_row(-1, 0, 0, 0, 30, 0, 0, 0, 0);
      add_row('h10000, 'h10000, 0, 0, 45, 0, 0, 0, 0);
      add_row('h12345, -'h6789, 'h1000, -'h2000, 32767, 0, 0, 0, 0);
      add_row(-'h12345, 'h6789, -'h1000, 'h2000, -32768, 0, 0, 0, 0);
      add_row('h4000, 'h1000, 0, 0, 89, 0, 0, 0, 0);
      add_row('h4000, 'h1000, 0, 0, 91, 0, 0, 0, 0);
      add_row('h4000, 'h1000, 0, 0, 179, 0, 0, 0, 0);
      add_row('h4000, 'h1000, 0, 0, 181, 0, 0, 0, 0);
      add_row('h4000, 'h1000, 0, 0, 269, 0, 0, 0, 0);
      add_row('h4000, 'h1000, 0, 0, 359, 0, 0, 0, 0);
      add_row(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 45, 0, 0, 0, 0);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].beat, directed_rows[i].typed ?
                   directed_rows[i].want : rotate_about_center(directed_rows[i].beat));
         maybe_idle(1'b0);
      end
      hold_until_drained(1000);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         beat = random_beat();
         send_beat(beat, rotate_about_center(beat));
         if (i == 1200) begin
            hold_until_drained(1000);
         end else begin
            maybe_idle(i >= 600 && i < 900);
         end
      end

      hold_until_drained(5000);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (expected_rotations.size() != 0) begin
         $display("%0t ns: %0d results never arrived", $time, expected_rotations.size());
         mismatch_count += expected_rotations.size();
      end

      $display("Sent %0d beats (%0d from the directed table), checked %0d results.",
               beats_sent, directed_rows.size(), results_seen);
      $display("%0d results saturated; %0d mismatches.", clipped_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("%0t ns: run did not finish in time", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
